>>> design/morse_keying_decoder_defines.svh
// Assertion macros shared by the decoder modules.
`ifndef MORSE_KEYING_DECODER_DEFINES_SVH
`define MORSE_KEYING_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define MKD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MKD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MKD_ASSERT(lbl, prop, msg)
`define MKD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/mkd_pkg.sv
package mkd_pkg;

    localparam int CODE_BITS_DEFAULT  = 16;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int CODE_BITS_MAX      = 32;
    localparam int CFG_BITS           = 16;
    localparam int CHAR_BITS          = 7;
    localparam int QUEUE_DEPTH        = 2;
    localparam int ADDR_BITS          = 4;
    localparam int DATA_BITS          = 32;

    localparam logic [1:0] SYM_DOT  = 2'b01;
    localparam logic [1:0] SYM_DASH = 2'b10;

    localparam logic [CFG_BITS-1:0] DOT_MAX_RESET      = 16'd1;
    localparam logic [CFG_BITS-1:0] LETTER_GAP_RESET   = 16'd4;
    localparam logic [CFG_BITS-1:0] IDLE_TIMEOUT_RESET = 16'd15;

    localparam logic [CHAR_BITS-1:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 7'h00;

    typedef enum logic [1:0] {
        REG_DOT_MAX      = 2'd0,
        REG_LETTER_GAP   = 2'd1,
        REG_IDLE_TIMEOUT = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_SPACE = 2'd1,
        EV_START = 2'd2,
        EV_END   = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] dot_max;
        logic [CFG_BITS-1:0] letter_gap;
        logic [CFG_BITS-1:0] idle_timeout;
    } cfg_t;

    // one queue entry holds every result of one tick (one or two)
    typedef struct packed {
        logic                 two;
        event_kind_t          kind0;
        logic [CHAR_BITS-1:0] char0;
        event_kind_t          kind1;
        logic [CHAR_BITS-1:0] char1;
    } entry_t;

    // 2 bits per symbol, newest symbol in the low bits
    function automatic logic [CHAR_BITS-1:0] decode_char(input logic [CODE_BITS_MAX-1:0] code);
        logic [CHAR_BITS-1:0] ch;
        case (code)
            32'h0006: ch = 7'h41;
            32'h0095: ch = 7'h42;
            32'h0099: ch = 7'h43;
            32'h0025: ch = 7'h44;
            32'h0001: ch = 7'h45;
            32'h0059: ch = 7'h46;
            32'h0029: ch = 7'h47;
            32'h0055: ch = 7'h48;
            32'h0005: ch = 7'h49;
            32'h006A: ch = 7'h4A;
            32'h0026: ch = 7'h4B;
            32'h0065: ch = 7'h4C;
            32'h000A: ch = 7'h4D;
            32'h0009: ch = 7'h4E;
            32'h002A: ch = 7'h4F;
            32'h0069: ch = 7'h50;
            32'h00A6: ch = 7'h51;
            32'h0019: ch = 7'h52;
            32'h0015: ch = 7'h53;
            32'h0002: ch = 7'h54;
            32'h0016: ch = 7'h55;
            32'h0056: ch = 7'h56;
            32'h001A: ch = 7'h57;
            32'h0096: ch = 7'h58;
            32'h009A: ch = 7'h59;
            32'h00A5: ch = 7'h5A;
            32'h01AA: ch = 7'h31;
            32'h016A: ch = 7'h32;
            32'h015A: ch = 7'h33;
            32'h0156: ch = 7'h34;
            32'h0155: ch = 7'h35;
            32'h0255: ch = 7'h36;
            32'h0295: ch = 7'h37;
            32'h02A5: ch = 7'h38;
            32'h02A9: ch = 7'h39;
            32'h02AA: ch = 7'h30;
            default:  ch = CHAR_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

>>> design/mkd_cfg.sv
module mkd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mkd_pkg::DATA_BITS-1:0] pwdata,
    output logic [mkd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output mkd_pkg::cfg_t                 cfg
);
    import mkd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_DOT_MAX:      cfg_next.dot_max      = pwdata[CFG_BITS-1:0];
                REG_LETTER_GAP:   cfg_next.letter_gap   = pwdata[CFG_BITS-1:0];
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = pwdata[CFG_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DOT_MAX:      prdata = DATA_BITS'(cfg_reg.dot_max);
            REG_LETTER_GAP:   prdata = DATA_BITS'(cfg_reg.letter_gap);
            REG_IDLE_TIMEOUT: prdata = DATA_BITS'(cfg_reg.idle_timeout);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_max      <= DOT_MAX_RESET;
            cfg_reg.letter_gap   <= LETTER_GAP_RESET;
            cfg_reg.idle_timeout <= IDLE_TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/mkd_front.sv
`include "morse_keying_decoder_defines.svh"

module mkd_front #(
    parameter int CODE_BITS  = mkd_pkg::CODE_BITS_DEFAULT,
    parameter int COUNT_BITS = mkd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            key_level,
    input  mkd_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            push,
    output mkd_pkg::entry_t push_entry
);
    import mkd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  prev_reg, prev_next;
    logic                  listen_reg, listen_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]      dur;
    logic [CHAR_BITS-1:0]  char_dec;
    logic                  level_change;
    logic                  in_accept;
    logic [1:0]            n_ev;
    entry_t                entry;

    assign in_ready     = !q_full;
    assign in_accept    = in_valid && in_ready;
    assign level_change = key_level != prev_reg;
    assign cnt_inc      = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign dur          = CMP_W'(cnt_inc);
    // a timeout never follows an edge in the same tick, so the pending code is code_reg
    assign char_dec     = decode_char(CODE_BITS_MAX'(code_reg));

    always_comb
    begin
        prev_next   = prev_reg;
        listen_next = listen_reg;
        code_next   = code_reg;
        cnt_next    = cnt_inc;
        n_ev        = 2'd0;
        entry.two   = 1'b0;
        entry.kind0 = EV_CHAR;
        entry.char0 = CHAR_NONE;
        entry.kind1 = EV_END;
        entry.char1 = CHAR_NONE;

        if (level_change)
        begin
            prev_next = key_level;
            cnt_next  = '0;
            if (key_level)
            begin
                if (!listen_reg)
                begin
                    listen_next = 1'b1;
                    entry.kind0 = EV_START;
                    n_ev        = 2'd1;
                end
                else if (dur > CMP_W'(cfg.dot_max))
                begin
                    entry.kind0 = EV_CHAR;
                    entry.char0 = char_dec;
                    code_next   = '0;
                    n_ev        = 2'd1;
                    if (dur > CMP_W'(cfg.letter_gap))
                    begin
                        entry.kind1 = EV_SPACE;
                        entry.char1 = CHAR_SPACE;
                        n_ev        = 2'd2;
                    end
                end
            end
            else
            begin
                code_next = {code_reg[CODE_BITS-3:0],
                             (dur <= CMP_W'(cfg.dot_max)) ? SYM_DOT : SYM_DASH};
            end
        end

        if (!prev_next && listen_next && (CMP_W'(cnt_next) > CMP_W'(cfg.idle_timeout)))
        begin
            listen_next = 1'b0;
            if (code_next != '0)
            begin
                entry.kind0 = EV_CHAR;
                entry.char0 = char_dec;
                entry.kind1 = EV_END;
                entry.char1 = CHAR_NONE;
                n_ev        = 2'd2;
                code_next   = '0;
            end
            else
            begin
                entry.kind0 = EV_END;
                entry.char0 = CHAR_NONE;
                n_ev        = 2'd1;
            end
        end

        entry.two = n_ev == 2'd2;
    end

    assign push       = in_accept && (n_ev != 2'd0);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            listen_reg <= 1'b0;
            code_reg   <= '0;
            cnt_reg    <= '0;
        end
        else if (in_accept)
        begin
            prev_reg   <= prev_next;
            listen_reg <= listen_next;
            code_reg   <= code_next;
            cnt_reg    <= cnt_next;
        end
    end

    `MKD_ASSERT(a_front_hold, !in_accept |=> $stable(listen_reg) && $stable(cnt_reg), "front state moved without an item")

endmodule

>>> design/mkd_fifo.sv
`include "morse_keying_decoder_defines.svh"

module mkd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mkd_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mkd_pkg::entry_t head
);
    import mkd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    entry_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    `MKD_ASSERT(a_fifo_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `MKD_ASSERT(a_fifo_no_underrun, pop |-> head_valid, "pop from empty queue")

endmodule

>>> design/mkd_back.sv
`include "morse_keying_decoder_defines.svh"

module mkd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  mkd_pkg::entry_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_kind,
    output logic [mkd_pkg::CHAR_BITS-1:0] char_code,
    output logic                          last_of_tick
);
    import mkd_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 sub_reg, sub_next;
    event_kind_t          kind_reg;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 last_reg;
    logic                 load;

    // output register refills while its item is being taken
    assign load = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (!sub_reg && head.two)
            begin
                sub_next = 1'b1;
            end
            else
            begin
                sub_next = 1'b0;
                pop      = 1'b1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sub_reg)
            begin
                kind_reg <= head.kind1;
                char_reg <= head.char1;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= head.kind0;
                char_reg <= head.char0;
                last_reg <= !head.two;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign event_kind   = kind_reg;
    assign char_code    = char_reg;
    assign last_of_tick = last_reg;

    `MKD_ASSERT(a_back_sub_head, sub_reg |-> head_valid && head.two, "second result without a paired entry")
    `MKD_ASSERT(a_back_pop_last, pop |=> valid_reg && last_reg, "entry retired before its last result")

endmodule

>>> design/morse_keying_decoder.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     key_level
// output    out_valid / out_ready   event_kind, char_code, last_of_tick
// config    psel / penable / pready paddr, pwdata, prdata (APB write/read)
//
// One key sample is taken per cycle while in_ready is high; a tick's one or two
// results pass through the result queue into the output register, one result per
// cycle while out_ready is high. in_ready drops only when the two-entry result queue is full.
// rst_n clears control state, not queue/output data; no clearing pass follows reset.
// Output stalls back up through the queue to in_ready; the front never waits otherwise.
module morse_keying_decoder #(
    parameter int CODE_BITS  = mkd_pkg::CODE_BITS_DEFAULT,
    parameter int COUNT_BITS = mkd_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          key_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_kind,
    output logic [mkd_pkg::CHAR_BITS-1:0] char_code,
    output logic                          last_of_tick,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mkd_pkg::DATA_BITS-1:0] pwdata,
    output logic [mkd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import mkd_pkg::*;

    cfg_t   cfg;
    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head;

    mkd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mkd_front #(
        .CODE_BITS  (CODE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_level  (key_level),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mkd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mkd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .char_code    (char_code),
        .last_of_tick (last_of_tick)
    );

endmodule

>>> tb/morse_keying_decoder_test.sv
typedef struct {
    mkd_pkg::event_kind_t kind;
    logic [6:0]           ch;
    logic                 last;
} key_event_t;

class key_event_scoreboard;
    logic [15:0] dot_max;
    logic [15:0] letter_gap;
    logic [15:0] idle_timeout;
    logic        line_level;
    logic        listening;
    logic [15:0] code;
    logic [15:0] ticks;
    key_event_t  upcoming[$];
    int          errors;
    int          seen;

    function new();
        dot_max      = mkd_pkg::DOT_MAX_RESET;
        letter_gap   = mkd_pkg::LETTER_GAP_RESET;
        idle_timeout = mkd_pkg::IDLE_TIMEOUT_RESET;
        line_level   = 1'b0;
        listening    = 1'b0;
        code         = '0;
        ticks        = '0;
        errors       = 0;
        seen         = 0;
    endfunction

    function void set_reg(mkd_pkg::reg_index_t idx, logic [15:0] value);
        case (idx)
            mkd_pkg::REG_DOT_MAX:      dot_max = value;
            mkd_pkg::REG_LETTER_GAP:   letter_gap = value;
            mkd_pkg::REG_IDLE_TIMEOUT: idle_timeout = value;
            default: ;
        endcase
    endfunction

    // walk the dot/dash table, building each code the same way the keyer does
    function logic [6:0] letter_of(logic [15:0] c);
        string       pats;
        string       names;
        logic [15:0] acc;
        byte         b;
        int          k;
        int          i;
        pats  = {".- -... -.-. -.. . ..-. --. .... .. .--- -.- .-.. -- -. --- .--. ",
                 "--.- .-. ... - ..- ...- .-- -..- -.-- --.. .---- ..--- ...-- ....- ",
                 "..... -.... --... ---.. ----. -----"};
        names = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
        acc = '0;
        k = 0;
        for (i = 0; i <= pats.len(); i++)
        begin
            if (i == pats.len() || pats[i] == " ")
            begin
                if (acc == c)
                begin
                    b = names[k];
                    return b[6:0];
                end
                acc = '0;
                k++;
            end
            else
                acc = {acc[13:0], (pats[i] == ".") ? mkd_pkg::SYM_DOT : mkd_pkg::SYM_DASH};
        end
        return mkd_pkg::CHAR_UNKNOWN;
    endfunction

    function void push_event(mkd_pkg::event_kind_t kind, logic [6:0] ch);
        key_event_t e;
        e.kind = kind;
        e.ch   = ch;
        e.last = 1'b0;
        upcoming.push_back(e);
    endfunction

    function void take_key(logic level);
        int          n0;
        logic [15:0] span;
        n0 = upcoming.size();
        if (ticks != '1)
            ticks = ticks + 16'd1;
        if (level != line_level)
        begin
            span       = ticks;
            line_level = level;
            ticks      = '0;
            if (level)
            begin
                if (!listening)
                begin
                    listening = 1'b1;
                    push_event(mkd_pkg::EV_START, mkd_pkg::CHAR_NONE);
                end
                else if (span > dot_max)
                begin
                    push_event(mkd_pkg::EV_CHAR, letter_of(code));
                    code = '0;
                    if (span > letter_gap)
                        push_event(mkd_pkg::EV_SPACE, mkd_pkg::CHAR_SPACE);
                end
            end
            else
                code = {code[13:0], (span <= dot_max) ? mkd_pkg::SYM_DOT : mkd_pkg::SYM_DASH};
        end
        if (!line_level && listening && ticks > idle_timeout)
        begin
            if (code != '0)
            begin
                push_event(mkd_pkg::EV_CHAR, letter_of(code));
                code = '0;
            end
            push_event(mkd_pkg::EV_END, mkd_pkg::CHAR_NONE);
            listening = 1'b0;
        end
        if (upcoming.size() > n0)
            upcoming[upcoming.size() - 1].last = 1'b1;
    endfunction

    function void match_event(logic [1:0] kind, logic [6:0] ch, logic last);
        key_event_t e;
        seen++;
        if (upcoming.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected event: kind=%0d char=%h last=%0b", kind, ch, last);
            return;
        end
        e = upcoming.pop_front();
        if (kind !== e.kind || ch !== e.ch || last !== e.last)
        begin
            errors++;
            if (errors <= 10)
                $display("event mismatch: expected kind=%0d char=%h last=%0b, got kind=%0d char=%h last=%0b",
                         e.kind, e.ch, e.last, kind, ch, last);
        end
    endfunction

    function void close_out();
        if (upcoming.size() != 0)
        begin
            $display("%0d expected events never arrived", upcoming.size());
            errors += upcoming.size();
        end
    endfunction
endclass

module morse_keying_decoder_test;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        key_level = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_kind;
    logic [mkd_pkg::CHAR_BITS-1:0] char_code;
    logic        last_of_tick;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [mkd_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [mkd_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [mkd_pkg::DATA_BITS-1:0] prdata;
    logic        pready;

    key_event_scoreboard sb;
    int sender_pct = 0;
    int stall_pct = 0;
    int samples = 0;
    int reg_writes = 0;

    // register settings per random phase: dot limit, letter gap, idle timeout
    int dot_set[6]  = '{1, 2, 1, 3, 4, 2};
    int gap_set[6]  = '{4, 6, 1, 9, 2, 5};
    int idle_set[6] = '{15, 20, 1, 25, 6, 12};

    morse_keying_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_level    (key_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .char_code    (char_code),
        .last_of_tick (last_of_tick),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 700000);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_pct > 0)
            out_ready <= ($urandom_range(99) >= stall_pct);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.match_event(event_kind, char_code, last_of_tick);
    end

    task set_idling(int mode);
        case (mode)
            1: begin sender_pct = 60; stall_pct = 0;  end
            2: begin sender_pct = 0;  stall_pct = 60; end
            3: begin sender_pct = 28; stall_pct = 28; end
            default: begin sender_pct = 0; stall_pct = 0; end
        endcase
    endtask

    function int span(int lo, int hi);
        if (hi < lo)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    task send_level(logic lvl);
        if (sender_pct > 0 && $urandom_range(99) < sender_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_pct);
        end
        in_valid  <= 1'b1;
        key_level <= lvl;
        do @(posedge clk); while (!in_ready);
        sb.take_key(lvl);
        samples++;
    endtask

    task key_run(logic lvl, int n);
        repeat (n) send_level(lvl);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.upcoming.size() != 0)
            @(posedge clk);
        // a tick with no events may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task write_reg(mkd_pkg::reg_index_t idx, logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom_range(16'hFFFF, 0));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task send_letter(int nsym);
        int s;
        int dot;
        dot = int'(sb.dot_max);
        for (s = 0; s < nsym; s++)
        begin
            if (s > 0)
                key_run(1'b0, span(1, dot));
            if ($urandom_range(1))
                key_run(1'b1, span(1, dot));
            else
                key_run(1'b1, span(dot + 1, dot + 3));
        end
    endtask

    // mostly well-formed words, some noise; each word end is picked at random
    // between a word space and an idle timeout
    task keying_phase(int budget);
        int stop;
        int letters;
        int nsym;
        int pick;
        int l;
        stop = samples + budget;
        while (samples < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                repeat ($urandom_range(8, 1)) send_level(1'($urandom_range(1, 0)));
            else
            begin
                letters = $urandom_range(4, 1);
                for (l = 0; l < letters; l++)
                begin
                    // now and then more symbols than the code register holds
                    nsym = ($urandom_range(19) == 0) ? $urandom_range(10, 6) : $urandom_range(5, 1);
                    send_letter(nsym);
                    if (l < letters - 1)
                        key_run(1'b0, span(sb.dot_max + 1, sb.letter_gap));
                    else if (pick < 60)
                        key_run(1'b0, span(sb.letter_gap + 1, sb.letter_gap + 4));
                    else
                        key_run(1'b0, span(sb.idle_timeout + 2, sb.idle_timeout + 5));
                end
            end
        end
    endtask

    initial
    begin
        int ph;
        sb = new();
        set_idling(0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: dot, dash, letter end, word space, timeout with a pending letter
        key_run(1'b1, 1);
        key_run(1'b0, 1);
        key_run(1'b1, 2);
        key_run(1'b0, 3);
        key_run(1'b1, 1);
        key_run(1'b0, 5);
        key_run(1'b1, 2);
        key_run(1'b0, 17);
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            write_reg(mkd_pkg::REG_DOT_MAX, 16'(dot_set[ph]));
            write_reg(mkd_pkg::REG_LETTER_GAP, 16'(gap_set[ph]));
            write_reg(mkd_pkg::REG_IDLE_TIMEOUT, 16'(idle_set[ph]));
            set_idling(ph % 4);
            keying_phase(220);
            drain();
        end

        // make sure listening has ended before the register extremes
        key_run(1'b0, 40);
        drain();
        set_idling(0);
        write_reg(mkd_pkg::REG_DOT_MAX, 16'hFFFF);
        write_reg(mkd_pkg::REG_LETTER_GAP, 16'hFFFF);
        write_reg(mkd_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
        write_reg(mkd_pkg::REG_UNUSED, 16'($urandom_range(16'hFFFF, 0)));
        // at the maximum every pulse is a dot and no gap ends a letter
        key_run(1'b1, 3);
        key_run(1'b0, 20);
        key_run(1'b1, 2);
        key_run(1'b0, 1);
        drain();

        repeat (8) @(posedge clk);
        sb.close_out();
        $display("Keyed %0d samples through %0d register writes; %0d decoder events compared.",
                 samples, reg_writes, sb.seen);
        $display("Covered dots, dashes, gaps, timeouts, overlong letters, noise and maximum settings.");
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
